>>> sv/drpc_pkg.sv
package drpc_pkg;

	localparam int DIGITS = 11;
	localparam int BIN_W  = 37;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int DIG_W  = 4;
	localparam int LEN_W  = 4;
	localparam int TAG_W  = 16;
	localparam int CNT_W  = $clog2(BIN_W);

	function automatic longint unsigned pow10(input int n);
		longint unsigned v;
		v = 1;
		for (int i = 0; i < n; i++) begin
			v = v * 10;
		end
		return v;
	endfunction

	// largest value with DIGITS decimal digits
	localparam logic [BIN_W-1:0] LIMIT = BIN_W'(pow10(DIGITS) - 1);
	localparam logic [DIG_W-1:0] DIGIT_NINE = 4'd9;
	localparam logic [DIG_W-1:0] DIGIT_ZERO = 4'd0;
	localparam logic [BCD_W-1:0] ALL_NINES = {DIGITS{DIGIT_NINE}};

	typedef struct packed {
		logic [BIN_W-1:0] stem_value;
		logic [LEN_W-1:0] stem_length;
		logic             has_digit_run;
		logic [DIG_W-1:0] run_first_digit;
		logic [DIG_W-1:0] run_last_digit;
		logic [TAG_W-1:0] tag_out;
		logic             range_error;
		logic             end_of_cover;
	} item_t;

	// add 3 to every BCD digit of 5 or more ahead of the next shift
	function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		r = b;
		for (int k = 0; k < DIGITS; k++) begin
			if (b[4*k +: 4] >= 4'd5) begin
				r[4*k +: 4] = b[4*k +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	// append one decimal digit to a stem
	function automatic logic [BIN_W-1:0] append_digit(input logic [BIN_W-1:0] s,
			input logic [DIG_W-1:0] dg);
		return (s << 3) + (s << 1) + BIN_W'(dg);
	endfunction

endpackage

>>> sv/drpc_in_if.sv
interface drpc_in_if;
	logic                          valid;
	logic                          ready;
	logic [drpc_pkg::BIN_W-1:0]    range_low;
	logic [drpc_pkg::BIN_W-1:0]    range_high;
	logic [drpc_pkg::TAG_W-1:0]    operator_tag;

	modport source (output valid, output range_low, output range_high,
		output operator_tag, input ready);
	modport sink (input valid, input range_low, input range_high,
		input operator_tag, output ready);
endinterface

>>> sv/drpc_out_if.sv
interface drpc_out_if;
	logic                          valid;
	logic                          ready;
	logic [drpc_pkg::BIN_W-1:0]    stem_value;
	logic [drpc_pkg::LEN_W-1:0]    stem_length;
	logic                          has_digit_run;
	logic [drpc_pkg::DIG_W-1:0]    run_first_digit;
	logic [drpc_pkg::DIG_W-1:0]    run_last_digit;
	logic [drpc_pkg::TAG_W-1:0]    tag_out;
	logic                          range_error;
	logic                          end_of_cover;

	modport source (output valid, output stem_value, output stem_length,
		output has_digit_run, output run_first_digit, output run_last_digit,
		output tag_out, output range_error, output end_of_cover, input ready);
	modport sink (input valid, input stem_value, input stem_length,
		input has_digit_run, input run_first_digit, input run_last_digit,
		input tag_out, input range_error, input end_of_cover, output ready);
endinterface

>>> sv/decimal_range_to_prefix_cover.sv
// Decimal range to prefix cover.
// item_in carries an inclusive range (range_low..range_high) of DIGITS-digit
// decimal numbers plus an operator tag; item_out returns the decimal prefixes
// that cover the range exactly, one item per prefix run, low-end walk first,
// then the middle run, then the high-end walk, with end_of_cover set on the
// last item of each range. A reversed range (low above high, after clamping
// both ends to 10^DIGITS-1) yields a single item with range_error set.
// Timing: one input item at a time. After acceptance the block checks the
// range, converts both ends to BCD one bit per cycle (shift-and-add-3), then
// scans the common stem and walks the low end digit by digit, emits the
// middle run and walks the high end. The error item of a reversed range
// comes straight from the range check, with no conversion.
// item_in.ready rises again as soon as the last result sits in the output
// register, so the next range may be accepted while that result still waits.
// A stalled receiver (item_out.ready low) halts the walk at the next step that
// produces an item: the output register holds its item until taken. Reset (arst_n low) empties it and returns to idle.
module decimal_range_to_prefix_cover (
	input  logic           clk,
	input  logic           arst_n,
	drpc_in_if.sink        item_in,
	drpc_out_if.source     item_out
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_CONV  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_UP    = 3'd4;
	localparam logic [2:0] ST_MID   = 3'd5;
	localparam logic [2:0] ST_DOWN  = 3'd6;

	localparam int BIN_W = drpc_pkg::BIN_W;
	localparam int BCD_W = drpc_pkg::BCD_W;
	localparam int DIG_W = drpc_pkg::DIG_W;
	localparam int LEN_W = drpc_pkg::LEN_W;
	localparam int CNT_W = drpc_pkg::CNT_W;

	// control
	logic [2:0]            state_q;
	logic                  out_valid_q;

	// payload
	logic [BIN_W-1:0]      lo_q;        // clamped low end, then binary shifter
	logic [BIN_W-1:0]      hi_q;
	logic [drpc_pkg::TAG_W-1:0] tag_q;
	logic [CNT_W-1:0]      cnt_q;       // conversion bit counter
	logic [BCD_W-1:0]      bcdlo_q;     // low end digits, top digit is current
	logic [BCD_W-1:0]      bcdhi_q;
	logic [BIN_W-1:0]      stem_q;      // common stem
	logic [LEN_W-1:0]      len_q;       // common stem length
	logic [BIN_W-1:0]      walk_q;      // stem along the current walk
	logic [LEN_W-1:0]      pos_q;       // digit position along the walk
	logic [DIG_W-1:0]      mid_lo_q;    // low digit at the first difference
	drpc_pkg::item_t       out_q;

	logic                  accept;
	logic                  slot_free;
	logic                  emit;
	logic                  go;
	drpc_pkg::item_t       item;

	logic [DIG_W-1:0]      lo_top;
	logic [DIG_W-1:0]      hi_top;
	logic [BCD_W-1:0]      lo_rest;
	logic [BCD_W-1:0]      hi_rest;
	logic [DIG_W-1:0]      lo_next;
	logic [DIG_W-1:0]      hi_next;
	logic [DIG_W-1:0]      walk_digit;
	logic [BIN_W-1:0]      walk_next;
	logic [BIN_W-1:0]      stem_next;
	logic [BCD_W-1:0]      adj_lo;
	logic [BCD_W-1:0]      adj_hi;
	logic                  mid_nonempty;

	assign accept    = item_in.valid && item_in.ready;
	assign slot_free = !out_valid_q || item_out.ready;
	assign item_in.ready = (state_q == ST_IDLE);

	// digit views: lows refill with 0s, highs with 9s, so a finished tail
	// reads as all 0s / all 9s
	assign lo_top  = bcdlo_q[BCD_W-1 -: DIG_W];
	assign hi_top  = bcdhi_q[BCD_W-1 -: DIG_W];
	assign lo_rest = {bcdlo_q[BCD_W-DIG_W-1:0], drpc_pkg::DIGIT_ZERO};
	assign hi_rest = {bcdhi_q[BCD_W-DIG_W-1:0], drpc_pkg::DIGIT_NINE};
	assign lo_next = lo_rest[BCD_W-1 -: DIG_W];
	assign hi_next = hi_rest[BCD_W-1 -: DIG_W];

	assign walk_digit = (state_q == ST_DOWN) ? hi_top : lo_top;
	assign walk_next  = drpc_pkg::append_digit(walk_q, walk_digit);
	assign stem_next  = drpc_pkg::append_digit(stem_q, lo_top);

	assign adj_lo = drpc_pkg::dabble_adjust(bcdlo_q);
	assign adj_hi = drpc_pkg::dabble_adjust(bcdhi_q);

	assign mid_nonempty = ({1'b0, mid_lo_q} + 5'd2) <= {1'b0, hi_top};

	// build the item the current step produces, if any
	always_comb begin
		emit = 1'b0;
		item = '0;
		item.tag_out = tag_q;
		unique case (state_q)
			ST_CHECK: begin
				if (lo_q > hi_q) begin
					emit = 1'b1;
					item.range_error  = 1'b1;
					item.end_of_cover = 1'b1;
				end
			end
			ST_SCAN: begin
				if (lo_top != hi_top && bcdlo_q == '0 && bcdhi_q == drpc_pkg::ALL_NINES) begin
					emit = 1'b1;
					item.stem_value   = stem_q;
					item.stem_length  = len_q;
					item.end_of_cover = 1'b1;
				end
			end
			ST_UP: begin
				item.stem_value  = walk_next;
				item.stem_length = pos_q + LEN_W'(1);
				if (lo_rest == '0) begin
					emit = 1'b1;
				end else if (lo_next != drpc_pkg::DIGIT_NINE) begin
					emit = 1'b1;
					item.has_digit_run   = 1'b1;
					item.run_first_digit = lo_next + DIG_W'(1);
					item.run_last_digit  = drpc_pkg::DIGIT_NINE;
				end
			end
			ST_MID: begin
				if (mid_nonempty) begin
					emit = 1'b1;
					item.stem_value      = stem_q;
					item.stem_length     = len_q;
					item.has_digit_run   = 1'b1;
					item.run_first_digit = mid_lo_q + DIG_W'(1);
					item.run_last_digit  = hi_top - DIG_W'(1);
				end
			end
			ST_DOWN: begin
				item.stem_value  = walk_next;
				item.stem_length = pos_q + LEN_W'(1);
				if (hi_rest == drpc_pkg::ALL_NINES) begin
					emit = 1'b1;
					item.end_of_cover = 1'b1;
				end else if (hi_next != drpc_pkg::DIGIT_ZERO) begin
					emit = 1'b1;
					item.has_digit_run   = 1'b1;
					item.run_first_digit = drpc_pkg::DIGIT_ZERO;
					item.run_last_digit  = hi_next - DIG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// a step that produces an item waits for a free output slot
	assign go = !emit || slot_free;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (item_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (emit) begin
						if (go) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(BIN_W - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (lo_top != hi_top) begin
						if (emit) begin
							if (go) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_UP;
						end
					end
				end
				ST_UP: begin
					if (go && lo_rest == '0) begin
						state_q <= ST_MID;
					end
				end
				ST_MID: begin
					if (go) begin
						state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (go && hi_rest == drpc_pkg::ALL_NINES) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			out_q <= item;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// clamp each end to the largest DIGITS-digit number
					lo_q  <= (item_in.range_low  > drpc_pkg::LIMIT) ? drpc_pkg::LIMIT
						: item_in.range_low;
					hi_q  <= (item_in.range_high > drpc_pkg::LIMIT) ? drpc_pkg::LIMIT
						: item_in.range_high;
					tag_q <= item_in.operator_tag;
				end
			end
			ST_CHECK: begin
				cnt_q   <= '0;
				bcdlo_q <= '0;
				bcdhi_q <= '0;
			end
			ST_CONV: begin
				// shift one binary bit into the BCD digits
				bcdlo_q <= {adj_lo[BCD_W-2:0], lo_q[BIN_W-1]};
				bcdhi_q <= {adj_hi[BCD_W-2:0], hi_q[BIN_W-1]};
				lo_q    <= {lo_q[BIN_W-2:0], 1'b0};
				hi_q    <= {hi_q[BIN_W-2:0], 1'b0};
				cnt_q   <= cnt_q + CNT_W'(1);
				stem_q  <= '0;
				len_q   <= '0;
			end
			ST_SCAN: begin
				if (lo_top == hi_top) begin
					// extend the common stem by one digit
					stem_q  <= stem_next;
					len_q   <= len_q + LEN_W'(1);
					bcdlo_q <= lo_rest;
					bcdhi_q <= hi_rest;
				end else begin
					mid_lo_q <= lo_top;
					walk_q   <= stem_q;
					pos_q    <= len_q;
				end
			end
			ST_UP: begin
				if (go) begin
					walk_q  <= walk_next;
					pos_q   <= pos_q + LEN_W'(1);
					bcdlo_q <= lo_rest;
				end
			end
			ST_MID: begin
				if (go) begin
					walk_q <= stem_q;
					pos_q  <= len_q;
				end
			end
			ST_DOWN: begin
				if (go) begin
					walk_q  <= walk_next;
					pos_q   <= pos_q + LEN_W'(1);
					bcdhi_q <= hi_rest;
				end
			end
			default: begin
			end
		endcase
	end

	assign item_out.valid           = out_valid_q;
	assign item_out.stem_value      = out_q.stem_value;
	assign item_out.stem_length     = out_q.stem_length;
	assign item_out.has_digit_run   = out_q.has_digit_run;
	assign item_out.run_first_digit = out_q.run_first_digit;
	assign item_out.run_last_digit  = out_q.run_last_digit;
	assign item_out.tag_out         = out_q.tag_out;
	assign item_out.range_error     = out_q.range_error;
	assign item_out.end_of_cover    = out_q.end_of_cover;

endmodule

>>> sv/drpc_checker.sv
module drpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [drpc_pkg::BIN_W-1:0]    stem_value,
	input logic [drpc_pkg::LEN_W-1:0]    stem_length,
	input logic                          has_digit_run,
	input logic [drpc_pkg::DIG_W-1:0]    run_first_digit,
	input logic [drpc_pkg::DIG_W-1:0]    run_last_digit,
	input logic                          range_error,
	input logic                          end_of_cover
);

	// a stalled result stays valid with its stem, length and end marker unchanged
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stem_value)
			&& $stable(stem_length) && $stable(end_of_cover))
		else $error("result changed while stalled");

	// an error item closes its range and carries no prefix
	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> end_of_cover && !has_digit_run
			&& stem_length == '0 && stem_value == '0)
		else $error("malformed error item");

	// a digit run is ordered and stays within decimal digits
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_digit_run |-> run_first_digit <= run_last_digit
			&& run_last_digit <= drpc_pkg::DIGIT_NINE)
		else $error("bad digit run");

	// a stem alone carries zero run digits and fits the digit count
	a_stem_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_digit_run |-> run_first_digit == '0 && run_last_digit == '0
			&& stem_length <= drpc_pkg::LEN_W'(drpc_pkg::DIGITS))
		else $error("bad stem-only item");

	// a run item always has a stem shorter than the full number and is no error item
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_digit_run |-> stem_length < drpc_pkg::LEN_W'(drpc_pkg::DIGITS)
			&& !range_error)
		else $error("run item with full-length stem");

endmodule

bind decimal_range_to_prefix_cover drpc_checker u_drpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (item_out.valid),
	.out_ready       (item_out.ready),
	.stem_value      (item_out.stem_value),
	.stem_length     (item_out.stem_length),
	.has_digit_run   (item_out.has_digit_run),
	.run_first_digit (item_out.run_first_digit),
	.run_last_digit  (item_out.run_last_digit),
	.range_error     (item_out.range_error),
	.end_of_cover    (item_out.end_of_cover)
);

>>> sim/drpc_cover_checker.sv
module drpc_cover_checker (
	input  logic  clk,
	input  logic  arst_n,
	drpc_in_if    item_in,
	drpc_out_if   item_out,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import drpc_pkg::*;

	// digit i is decimal position i, most significant first
	typedef logic [DIGITS-1:0][DIG_W-1:0] digit_row_t;

	item_t due_prefixes[$];
	item_t seen;
	item_t due;
	int    failures = 0;
	int    reported = 0;
	int    waiting = 0;

	assign fail_count = failures;
	assign pending = waiting;

	function automatic digit_row_t to_digits(input longint unsigned v);
		digit_row_t dg;
		for (int i = DIGITS - 1; i >= 0; i--) begin
			dg[i] = DIG_W'(v % 10);
			v = v / 10;
		end
		return dg;
	endfunction

	// true when every digit from position 'from' to the end equals val
	function automatic bit tail_is(input digit_row_t dg, input int from,
			input logic [DIG_W-1:0] val);
		bit same;
		same = 1'b1;
		for (int i = from; i < DIGITS; i++) begin
			if (dg[i] != val) begin
				same = 1'b0;
			end
		end
		return same;
	endfunction

	function automatic item_t prefix_item(input digit_row_t dg, input int len,
			input bit run, input int first, input int last,
			input logic [TAG_W-1:0] tag);
		item_t it;
		longint unsigned stem;
		stem = 0;
		for (int i = 0; i < len; i++) begin
			stem = stem * 10 + dg[i];
		end
		it = '0;
		it.stem_value = BIN_W'(stem);
		it.stem_length = LEN_W'(len);
		it.has_digit_run = run;
		if (run) begin
			it.run_first_digit = DIG_W'(first);
			it.run_last_digit = DIG_W'(last);
		end
		it.tag_out = tag;
		return it;
	endfunction

	// append the prefix runs that cover lo..hi to the expected results
	function automatic void expand_range(input logic [BIN_W-1:0] lo_in,
			input logic [BIN_W-1:0] hi_in, input logic [TAG_W-1:0] tag);
		longint unsigned lo;
		longint unsigned hi;
		digit_row_t dl;
		digit_row_t dh;
		item_t last_one;
		int d;
		bit done;
		lo = lo_in;
		hi = hi_in;
		if (lo > LIMIT) begin
			lo = LIMIT;
		end
		if (hi > LIMIT) begin
			hi = LIMIT;
		end
		if (lo > hi) begin
			last_one = '0;
			last_one.tag_out = tag;
			last_one.range_error = 1'b1;
			due_prefixes.push_back(last_one);
		end else begin
			dl = to_digits(lo);
			dh = to_digits(hi);
			d = DIGITS;
			for (int i = DIGITS - 1; i >= 0; i--) begin
				if (dl[i] != dh[i]) begin
					d = i;
				end
			end
			if (tail_is(dl, d, DIGIT_ZERO) && tail_is(dh, d, DIGIT_NINE)) begin
				due_prefixes.push_back(prefix_item(dl, d, 1'b0, 0, 0, tag));
			end else begin
				done = 1'b0;
				for (int i = d; i < DIGITS && !done; i++) begin
					if (tail_is(dl, i + 1, DIGIT_ZERO)) begin
						due_prefixes.push_back(prefix_item(dl, i + 1, 1'b0, 0, 0, tag));
						done = 1'b1;
					end else if (dl[i+1] < DIGIT_NINE) begin
						due_prefixes.push_back(prefix_item(dl, i + 1, 1'b1,
							int'(dl[i+1]) + 1, int'(DIGIT_NINE), tag));
					end
				end
				if (int'(dl[d]) + 1 <= int'(dh[d]) - 1) begin
					due_prefixes.push_back(prefix_item(dl, d, 1'b1,
						int'(dl[d]) + 1, int'(dh[d]) - 1, tag));
				end
				done = 1'b0;
				for (int i = d; i < DIGITS && !done; i++) begin
					if (tail_is(dh, i + 1, DIGIT_NINE)) begin
						due_prefixes.push_back(prefix_item(dh, i + 1, 1'b0, 0, 0, tag));
						done = 1'b1;
					end else if (dh[i+1] > DIGIT_ZERO) begin
						due_prefixes.push_back(prefix_item(dh, i + 1, 1'b1,
							0, int'(dh[i+1]) - 1, tag));
					end
				end
			end
		end
		// flag the closing item of this range
		last_one = due_prefixes.pop_back();
		last_one.end_of_cover = 1'b1;
		due_prefixes.push_back(last_one);
	endfunction

	function automatic string item_text(input item_t it);
		return $sformatf("stem=%0d len=%0d run=%0b digits=%0d..%0d tag=%h err=%0b last=%0b",
			it.stem_value, it.stem_length, it.has_digit_run, it.run_first_digit,
			it.run_last_digit, it.tag_out, it.range_error, it.end_of_cover);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// results leave before new ranges enter, so a stray result is never
			// matched against a range accepted on the same edge
			if (item_out.valid && item_out.ready) begin
				seen.stem_value = item_out.stem_value;
				seen.stem_length = item_out.stem_length;
				seen.has_digit_run = item_out.has_digit_run;
				seen.run_first_digit = item_out.run_first_digit;
				seen.run_last_digit = item_out.run_last_digit;
				seen.tag_out = item_out.tag_out;
				seen.range_error = item_out.range_error;
				seen.end_of_cover = item_out.end_of_cover;
				if (due_prefixes.size() == 0) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("unexpected item: %s", item_text(seen));
					end
				end else begin
					due = due_prefixes.pop_front();
					if (seen.stem_value !== due.stem_value
							|| seen.stem_length !== due.stem_length
							|| seen.has_digit_run !== due.has_digit_run
							|| seen.run_first_digit !== due.run_first_digit
							|| seen.run_last_digit !== due.run_last_digit
							|| seen.tag_out !== due.tag_out
							|| seen.range_error !== due.range_error
							|| seen.end_of_cover !== due.end_of_cover) begin
						failures++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: expected %s", item_text(due));
							$display("          actual   %s", item_text(seen));
						end
					end
				end
			end
			if (item_in.valid && item_in.ready) begin
				expand_range(item_in.range_low, item_in.range_high, item_in.operator_tag);
			end
			waiting = due_prefixes.size();
		end
	end

endmodule

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import drpc_pkg::*;

	localparam int RANDOM_ITEMS   = 250;
	localparam int CYCLE_LIMIT    = 1_000_000;
	// longer than one full range conversion plus walk
	localparam int DRAIN_CYCLES   = 100;
	// long enough for the block to fill and drop item_in.ready
	localparam int SQUEEZE_CYCLES = 600;
	localparam logic [BIN_W-1:0] ALL_ONES = {BIN_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;

	drpc_in_if  item_in ();
	drpc_out_if item_out ();

	decimal_range_to_prefix_cover dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_in),
		.item_out (item_out)
	);

	// watches both channels, predicts every cover and counts failures
	drpc_cover_checker prefix_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.item_out   (item_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	// Hard stop: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Mostly no gap, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic longint unsigned rand_below(input longint unsigned bound);
		longint unsigned raw;
		raw = {$urandom, $urandom};
		return raw % bound;
	endfunction

	// Offer one range, hold it until taken, then idle for gap cycles.
	// valid stays high across back-to-back items so it is never dropped and
	// raised again in the same step.
	task automatic offer_range(input logic [BIN_W-1:0] lo, input logic [BIN_W-1:0] hi,
			input logic [TAG_W-1:0] tag, input int gap);
		item_in.valid <= 1'b1;
		item_in.range_low <= lo;
		item_in.range_high <= hi;
		item_in.operator_tag <= tag;
		@(posedge clk);
		while (!item_in.ready) begin
			@(posedge clk);
		end
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender: directed corner ranges, then random ranges, then drain and verdict.
	initial begin
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned span;
		longint unsigned base;
		longint unsigned swap;
		int kind;
		int depth;
		int gap;
		item_in.valid = 1'b0;
		item_in.range_low = '0;
		item_in.range_high = '0;
		item_in.operator_tag = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// equal ends at both extremes, and the whole number space
		offer_range('0, '0, 16'h0000, pick_gap());
		offer_range(LIMIT, LIMIT, 16'hFFFF, pick_gap());
		offer_range('0, LIMIT, 16'h1234, pick_gap());
		// reversed ranges
		offer_range(37'd5, 37'd3, 16'hA5A5, pick_gap());
		offer_range(LIMIT, '0, 16'h5A5A, pick_gap());
		// ends above the largest decimal value saturate first
		offer_range(ALL_ONES, ALL_ONES, 16'h8001, pick_gap());
		offer_range('0, ALL_ONES, 16'h7FFE, pick_gap());
		offer_range(ALL_ONES, 37'd5, 16'h0F0F, pick_gap());
		offer_range(37'd100, ALL_ONES, 16'hF0F0, pick_gap());
		// common stem alone, with and without leading digits
		offer_range(37'd12300000000, 37'd12399999999, 16'h3C3C, pick_gap());
		offer_range(37'd0, 37'd9, 16'hC3C3, pick_gap());
		// longest cover: every walk position emits an item
		offer_range(37'd1, 37'd99999999998, 16'h0001, 0);
		// empty middle run with adjacent ends, then a middle run of one digit
		offer_range(37'd19, 37'd20, 16'h0002, 0);
		offer_range(37'd5, 37'd7, 16'h0004, pick_gap());
		// low tail all zeros only, high tail all nines only
		offer_range(37'd1000, 37'd1234, 16'h0008, pick_gap());
		offer_range(37'd1234, 37'd1999, 16'h0010, pick_gap());
		offer_range(37'd10000000000, 37'd99999999999, 16'h0020, pick_gap());
		offer_range(37'd54321098765, 37'd54321098766, 16'h8000, pick_gap());
		offer_range(37'd99999999990, ALL_ONES, 16'h4000, pick_gap());
		offer_range('0, 37'd99999999989, 16'h2000, pick_gap());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				// raw noise over the full port width: saturation and reversal
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end else if (kind < 30) begin
				lo = $urandom_range(0, 250);
				hi = $urandom_range(0, 250);
			end else begin
				// well-formed range inside a block of 10^depth values
				depth = $urandom_range(0, DIGITS);
				span = 1;
				repeat (depth) span = span * 10;
				base = rand_below(LIMIT + 1) / span * span;
				case (kind % 4)
					0: begin
						lo = base;
						hi = base + span - 1;
					end
					1: begin
						lo = base;
						hi = base + rand_below(span);
					end
					2: begin
						lo = base + rand_below(span);
						hi = base + span - 1;
					end
					default: begin
						lo = base + rand_below(span);
						hi = base + rand_below(span);
						if (lo > hi) begin
							swap = lo;
							lo = hi;
							hi = swap;
						end
					end
				endcase
			end
			// hold back-to-back bursts now and then
			gap = (n % 40 < 8) ? 0 : pick_gap();
			offer_range(BIN_W'(lo), BIN_W'(hi), TAG_W'($urandom), gap);
		end
		item_in.valid <= 1'b0;

		// let the checker see the last accepted range before polling
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Receiver: random ready pattern, with one long hold-off once enough
	// results have passed so the block backs up into its input.
	initial begin
		int stretch;
		int taken;
		bit squeezed;
		taken = 0;
		squeezed = 1'b0;
		item_out.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			item_out.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) begin
				@(posedge clk);
				if (item_out.valid && item_out.ready) begin
					taken++;
				end
			end
			if (!squeezed && taken >= 80) begin
				stretch = SQUEEZE_CYCLES;
				squeezed = 1'b1;
			end else begin
				stretch = pick_gap();
			end
			if (stretch > 0) begin
				item_out.ready <= 1'b0;
				repeat (stretch) @(posedge clk);
			end
		end
	end

endmodule

>>> filelist.f
sv/drpc_pkg.sv
sv/drpc_in_if.sv
sv/drpc_out_if.sv
sv/decimal_range_to_prefix_cover.sv
sv/drpc_checker.sv
sim/drpc_cover_checker.sv
sim/tb.sv
